// ===== rtl/ntt_tf_pkg.sv =====
// shared constants, types and helpers for the ntt twiddle factor generator
package ntt_tf_pkg;

  localparam int unsigned MAX_LOG_DEGREE = 14;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned IDX_W          = 14;
  localparam int unsigned CNT_W          = $clog2(WORD_BITS);
  localparam int unsigned DEG_W          = 4;
  localparam int unsigned CFG_ADDR_W     = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_DEGREE  = 2'd1,
    CFG_ROOT    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } op_e;

  // operands of the shared add / compare / subtract unit
  typedef struct packed {
    logic [WORD_BITS-1:0] x;
    logic [WORD_BITS-1:0] y;
    logic                 cin;
    logic [WORD_BITS-1:0] m;
  } alu_req_t;

  function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      r[IDX_W-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ntt_tf_alu.sv =====
// shared unit: sum = x + y + cin, then subtract m when sum >= m
module ntt_tf_alu (
  input  ntt_tf_pkg::alu_req_t                 req_i,
  output logic [ntt_tf_pkg::WORD_BITS-1:0]     res_o,
  output logic                                 ge_o
);

  logic [ntt_tf_pkg::WORD_BITS:0] sum;
  logic [ntt_tf_pkg::WORD_BITS:0] diff;

  assign sum   = {1'b0, req_i.x} + {1'b0, req_i.y} + (ntt_tf_pkg::WORD_BITS+1)'(req_i.cin);
  assign ge_o  = sum >= {1'b0, req_i.m};
  assign diff  = sum - {1'b0, req_i.m};
  assign res_o = ge_o ? diff[ntt_tf_pkg::WORD_BITS-1:0] : sum[ntt_tf_pkg::WORD_BITS-1:0];

endmodule

// ===== rtl/ntt_twiddle_factor_generator.sv =====
// top level: twiddle factor and shoup factor generator on one shared adder
//
// usage
//   config: cfg_we_i / cfg_addr_i / cfg_wdata_i write modulus (0), degree_log2 (1)
//   and root (2); write only while the block is idle
//   input beat: s_axis_tuser = operation (0 forward, 1 inverse),
//   s_axis_tdata[13:0] = index; one request is taken when s_axis_tready is high,
//   which is only while the sequencer is idle
//   output beat: m_axis_tdata = {barrett_factor, twiddle}, m_axis_tuser =
//   index_error; the result sits in an output register, so the next request is
//   accepted while it waits
//   sequencing: at most one 64-bit add-and-reduce per cycle; out-of-range,
//   tiny-modulus and last-inverse requests go straight to done; otherwise
//   root mod q, then one modular multiply per exponent bit plus one per set
//   bit (up to 28 for 14-bit exponents), then for inverse entries euclid
//   steps, each a long division and a multiply, and then the shoup factor
//   reset: modulus 3, degree_log2 1, root 1, no output pending
//   stall: a finished result waits in the sequencer until the output register
//   is free, holding off further requests
module ntt_twiddle_factor_generator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [ntt_tf_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [ntt_tf_pkg::WORD_BITS-1:0]       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [15:0]                            s_axis_tdata,  // index[13:0], zero pad
  input  logic                                   s_axis_tuser,  // operation
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [2*ntt_tf_pkg::WORD_BITS-1:0]     m_axis_tdata,  // twiddle, barrett_factor
  output logic                                   m_axis_tuser   // index_error
);

  localparam int unsigned W   = ntt_tf_pkg::WORD_BITS;
  localparam int unsigned IW  = ntt_tf_pkg::IDX_W;
  localparam int unsigned CW  = ntt_tf_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RMOD, ST_POW_CHK, ST_MUL_DBL, ST_MUL_ADD, ST_MUL_RET,
    ST_EUC_CHK, ST_DIV, ST_QMOD, ST_SUBA, ST_SUBB, ST_SHOUP, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RET_POW_R, RET_POW_B, RET_EUC
  } ret_e;

  logic [W-1:0]                         modulus_q;
  logic [ntt_tf_pkg::DEG_W-1:0]         degree_q;
  logic [W-1:0]                         root_q;

  state_e                               state_q;
  ret_e                                 ret_q;
  logic [CW-1:0]                        cnt_q;
  logic                                 op_q;
  logic                                 kzero_q;
  logic [IW-1:0]                        exp_q;
  logic [W-1:0]                         base_q, r_q, acc_q, ma_q, mb_q;
  logic [W-1:0]                         r0_q, r1_q, t0_q, t1_q, rem_q, quo_q;
  logic [W-1:0]                         tw_q, fac_q;
  logic                                 err_q;
  logic                                 m_valid_q;
  logic [W-1:0]                         out_tw_q, out_fac_q;
  logic                                 out_err_q;

  ntt_tf_pkg::alu_req_t                 alu_req;
  logic [W-1:0]                         alu_res;
  logic                                 alu_ge;

  logic [3:0]                           lg;
  logic [IW:0]                          n_val;
  logic [IW-1:0]                        k_in;
  logic                                 k_range_err;
  logic                                 k_last;
  logic [IW-1:0]                        t_val;
  logic [IW-1:0]                        m_pow;
  logic [IW+1:0]                        src_wide;
  logic [IW-1:0]                        src;
  logic [IW-1:0]                        exp_in;
  logic                                 s_acc;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= W'(3);
      degree_q  <= ntt_tf_pkg::DEG_W'(1);
      root_q    <= W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ntt_tf_pkg::CFG_MODULUS: modulus_q <= cfg_wdata_i;
        ntt_tf_pkg::CFG_DEGREE:  degree_q  <= cfg_wdata_i[ntt_tf_pkg::DEG_W-1:0];
        ntt_tf_pkg::CFG_ROOT:    root_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request decode
  always_comb begin
    if (degree_q == '0) begin
      lg = 4'd1;
    end else if (degree_q > 4'(ntt_tf_pkg::MAX_LOG_DEGREE)) begin
      lg = 4'(ntt_tf_pkg::MAX_LOG_DEGREE);
    end else begin
      lg = degree_q;
    end
    n_val       = (IW+1)'(1) << lg;
    k_in        = s_axis_tdata[IW-1:0];
    k_range_err = {1'b0, k_in} >= n_val;
    k_last      = {1'b0, k_in} == (n_val - (IW+1)'(1));
    t_val       = IW'(n_val - (IW+1)'(1) - {1'b0, k_in});
    m_pow       = '0;
    for (int i = 0; i < IW; i++) begin
      if (t_val[i]) m_pow = IW'(1) << i;
    end
    src_wide = (IW+2)'(3) * (IW+2)'(m_pow) - (IW+2)'(1) - (IW+2)'(t_val);
    src      = src_wide[IW-1:0];
    exp_in   = ntt_tf_pkg::bit_rev(s_axis_tuser ? src : k_in) >> (4'(IW) - lg);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_RMOD: begin
        alu_req.x = rem_q; alu_req.y = rem_q; alu_req.cin = root_q[cnt_q]; alu_req.m = modulus_q;
      end
      ST_MUL_DBL: begin
        alu_req.x = acc_q; alu_req.y = acc_q; alu_req.m = modulus_q;
      end
      ST_MUL_ADD: begin
        alu_req.x = acc_q; alu_req.y = ma_q; alu_req.m = modulus_q;
      end
      ST_DIV: begin
        alu_req.x = rem_q; alu_req.y = rem_q; alu_req.cin = r0_q[cnt_q]; alu_req.m = r1_q;
      end
      ST_QMOD: begin
        alu_req.x = quo_q; alu_req.m = modulus_q;
      end
      ST_SUBA: begin
        alu_req.x = modulus_q; alu_req.y = ~acc_q; alu_req.cin = 1'b1;
      end
      ST_SUBB: begin
        alu_req.x = t0_q; alu_req.y = acc_q; alu_req.m = modulus_q;
      end
      ST_SHOUP: begin
        alu_req.x = rem_q; alu_req.y = rem_q; alu_req.m = modulus_q;
      end
      default: ;
    endcase
  end

  ntt_tf_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= RET_POW_R;
      cnt_q     <= '0;
      op_q      <= 1'b0;
      kzero_q   <= 1'b0;
      exp_q     <= '0;
      base_q    <= '0;
      r_q       <= '0;
      acc_q     <= '0;
      ma_q      <= '0;
      mb_q      <= '0;
      r0_q      <= '0;
      r1_q      <= '0;
      t0_q      <= '0;
      t1_q      <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      tw_q      <= '0;
      fac_q     <= '0;
      err_q     <= 1'b0;
      m_valid_q <= 1'b0;
      out_tw_q  <= '0;
      out_fac_q <= '0;
      out_err_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != ST_DONE) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            op_q    <= s_axis_tuser;
            kzero_q <= (k_in == '0);
            exp_q   <= exp_in;
            tw_q    <= '0;
            fac_q   <= '0;
            err_q   <= k_range_err;
            rem_q   <= '0;
            cnt_q   <= CW'(W-1);
            if (k_range_err || modulus_q < W'(2) ||
                (s_axis_tuser == ntt_tf_pkg::OP_INV && k_last)) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_RMOD;
            end
          end
        end
        ST_RMOD: begin
          rem_q <= alu_res;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            base_q  <= alu_res;
            r_q     <= W'(1);
            state_q <= ST_POW_CHK;
          end
        end
        ST_POW_CHK: begin
          acc_q <= '0;
          cnt_q <= CW'(W-1);
          if (exp_q == '0) begin
            if (op_q == ntt_tf_pkg::OP_FWD) begin
              tw_q <= r_q;
              if (kzero_q) begin
                state_q <= ST_DONE;
              end else begin
                rem_q   <= r_q;
                state_q <= ST_SHOUP;
              end
            end else begin
              r0_q    <= modulus_q;
              r1_q    <= r_q;
              t0_q    <= '0;
              t1_q    <= W'(1);
              state_q <= ST_EUC_CHK;
            end
          end else if (exp_q[0]) begin
            ma_q    <= r_q;
            mb_q    <= base_q;
            ret_q   <= RET_POW_R;
            state_q <= ST_MUL_DBL;
          end else begin
            ma_q    <= base_q;
            mb_q    <= base_q;
            ret_q   <= RET_POW_B;
            state_q <= ST_MUL_DBL;
          end
        end
        ST_MUL_DBL: begin
          acc_q <= alu_res;
          if (mb_q[cnt_q]) begin
            state_q <= ST_MUL_ADD;
          end else if (cnt_q == '0) begin
            state_q <= ST_MUL_RET;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_MUL_ADD: begin
          acc_q <= alu_res;
          if (cnt_q == '0) begin
            state_q <= ST_MUL_RET;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= ST_MUL_DBL;
          end
        end
        ST_MUL_RET: begin
          case (ret_q)
            RET_POW_R: begin
              r_q     <= acc_q;
              acc_q   <= '0;
              cnt_q   <= CW'(W-1);
              ma_q    <= base_q;
              mb_q    <= base_q;
              ret_q   <= RET_POW_B;
              state_q <= ST_MUL_DBL;
            end
            RET_POW_B: begin
              base_q  <= acc_q;
              exp_q   <= exp_q >> 1;
              state_q <= ST_POW_CHK;
            end
            default: begin
              state_q <= ST_SUBA;
            end
          endcase
        end
        ST_EUC_CHK: begin
          quo_q <= '0;
          cnt_q <= CW'(W-1);
          if (r1_q == '0) begin
            tw_q    <= (r0_q == W'(1)) ? t0_q : '0;
            rem_q   <= (r0_q == W'(1)) ? t0_q : '0;
            state_q <= ST_SHOUP;
          end else begin
            rem_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= alu_res;
          quo_q <= {quo_q[W-2:0], alu_ge};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) state_q <= ST_QMOD;
        end
        ST_QMOD: begin
          ma_q    <= alu_res;
          mb_q    <= t1_q;
          acc_q   <= '0;
          cnt_q   <= CW'(W-1);
          ret_q   <= RET_EUC;
          state_q <= ST_MUL_DBL;
        end
        ST_SUBA: begin
          acc_q   <= alu_res;
          state_q <= ST_SUBB;
        end
        ST_SUBB: begin
          r0_q    <= r1_q;
          r1_q    <= rem_q;
          t0_q    <= t1_q;
          t1_q    <= alu_res;
          state_q <= ST_EUC_CHK;
        end
        ST_SHOUP: begin
          rem_q <= alu_res;
          quo_q <= {quo_q[W-2:0], alu_ge};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            fac_q   <= {quo_q[W-2:0], alu_ge};
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            out_tw_q  <= tw_q;
            out_fac_q <= fac_q;
            out_err_q <= err_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_fac_q, out_tw_q};
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> out_tw_q == '0 && out_fac_q == '0)
    else $error("out of range result not zero");

  a_tw_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && modulus_q >= W'(2) |-> out_tw_q < modulus_q)
    else $error("twiddle not reduced");

  a_mul_add_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_ADD |-> mb_q[cnt_q])
    else $error("multiply add step on clear bit");
`endif

endmodule

// ===== tb/tb_ntt_twiddle_factor_generator.sv =====
// testbench for the ntt twiddle factor generator: randomized requests checked against a predictor
module tb_ntt_twiddle_factor_generator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    ntt_tf_pkg::op_e                  op;
    logic [ntt_tf_pkg::IDX_W-1:0]     idx;
  } request_t;

  typedef struct {
    logic [63:0] twiddle;
    logic [63:0] factor;
    logic        idx_err;
  } entry_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [63:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;

  request_t pending_q[$];
  entry_t   entry_q[$];
  logic [63:0] cur_mod = 64'd3;
  logic [3:0]  cur_deg = 4'd1;
  logic [63:0] cur_root = 64'd1;

  int unsigned in_gap, out_wait, hold_cnt;
  logic        hold_start = 1'b0;
  int unsigned n_err, n_beats, n_fwd, n_inv, n_oor, n_phase;
  int unsigned idx_list[6];

  ntt_twiddle_factor_generator u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b, logic [63:0] q);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, q});
  endfunction

  function automatic logic [63:0] pow_m(logic [63:0] b, logic [63:0] e, logic [63:0] q);
    logic [63:0] r;
    r = 64'd1 % q;
    while (e != 0) begin
      if (e[0]) r = mul_m(r, b, q);
      b = mul_m(b, b, q);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] inv_m(logic [63:0] a, logic [63:0] q);
    logic [63:0] r0, r1, t0, t1, qt, nr, p, nt;
    r0 = q;
    r1 = a;
    t0 = 0;
    t1 = 64'd1 % q;
    while (r1 != 0) begin
      qt = r0 / r1;
      nr = r0 - qt * r1;
      p  = mul_m(qt % q, t1, q);
      nt = (t0 >= p) ? t0 - p : t0 + (q - p);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    return (r0 == 1) ? t0 : 64'd0;
  endfunction

  function automatic logic [63:0] shoup_of(logic [63:0] v, logic [63:0] q);
    logic [127:0] num;
    num = {v, 64'd0};
    return 64'(num / {64'd0, q});
  endfunction

  function automatic logic [63:0] rev_bits(logic [63:0] x, int unsigned nb);
    logic [63:0] r;
    r = 0;
    for (int i = 0; i < nb; i++) r[nb-1-i] = x[i];
    return r;
  endfunction

  function automatic entry_t twiddle_entry(request_t rq);
    entry_t      e;
    int unsigned lg;
    logic [63:0] n, k, w, off, m, src;
    e = '{64'd0, 64'd0, 1'b0};
    lg = (cur_deg < 1) ? 1 :
         (cur_deg > ntt_tf_pkg::MAX_LOG_DEGREE) ? ntt_tf_pkg::MAX_LOG_DEGREE : cur_deg;
    n = 64'd1 << lg;
    k = rq.idx;
    if (k >= n) begin
      e.idx_err = 1'b1;
      return e;
    end
    if (cur_mod < 2) return e;
    w = cur_root % cur_mod;
    if (rq.op == ntt_tf_pkg::OP_FWD) begin
      e.twiddle = pow_m(w, rev_bits(k, lg), cur_mod);
      e.factor  = (k == 0) ? 64'd0 : shoup_of(e.twiddle, cur_mod);
    end else if (k != n - 1) begin
      off = 0;
      m = n >> 1;
      src = 0;
      while (m > 0) begin
        if (k < off + m) begin
          src = m + (k - off);
          break;
        end
        off += m;
        m >>= 1;
      end
      e.twiddle = inv_m(pow_m(w, rev_bits(src, lg), cur_mod), cur_mod);
      e.factor  = shoup_of(e.twiddle, cur_mod);
    end
    return e;
  endfunction

  // driver
  always @(posedge clk_i) begin
    request_t rq;
    int unsigned g;
    if (s_axis_tvalid && s_axis_tready) begin
      rq.op  = ntt_tf_pkg::op_e'(s_axis_tuser);
      rq.idx = s_axis_tdata[ntt_tf_pkg::IDX_W-1:0];
      entry_q.push_back(twiddle_entry(rq));
      g = $urandom_range(0, 3);
      if (g == 0 && pending_q.size() > 0) begin
        rq = pending_q.pop_front();
        s_axis_tdata <= {2'b00, rq.idx};
        s_axis_tuser <= rq.op;
      end else begin
        s_axis_tvalid <= 1'b0;
        in_gap <= g;
      end
    end else if (!s_axis_tvalid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0) begin
        rq = pending_q.pop_front();
        s_axis_tdata  <= {2'b00, rq.idx};
        s_axis_tuser  <= rq.op;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_start) hold_cnt <= 20000;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor
  always @(posedge clk_i) begin
    entry_t e;
    int unsigned w;
    if (m_axis_tvalid && m_axis_tready) begin
      n_beats++;
      if (entry_q.size() == 0) begin
        $error("unexpected beat: twiddle %h", m_axis_tdata[63:0]);
        n_err++;
      end else begin
        e = entry_q.pop_front();
        if (m_axis_tdata[63:0] !== e.twiddle) begin
          $error("twiddle: expected %h actual %h", e.twiddle, m_axis_tdata[63:0]);
          n_err++;
        end
        if (m_axis_tdata[127:64] !== e.factor) begin
          $error("barrett_factor: expected %h actual %h", e.factor, m_axis_tdata[127:64]);
          n_err++;
        end
        if (m_axis_tuser !== e.idx_err) begin
          $error("index_error: expected %0b actual %0b", e.idx_err, m_axis_tuser);
          n_err++;
        end
      end
      w = $urandom_range(0, 3);
      out_wait <= w;
      m_axis_tready <= (w == 0) && (hold_cnt == 0);
    end else begin
      if (out_wait > 0) out_wait <= out_wait - 1;
      m_axis_tready <= (out_wait <= 1) && (hold_cnt == 0) && !hold_start;
    end
  end

  task automatic wait_idle();
    while (!(pending_q.size() == 0 && !s_axis_tvalid && entry_q.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(ntt_tf_pkg::cfg_idx_e a, logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (a)
      ntt_tf_pkg::CFG_MODULUS: cur_mod = v;
      ntt_tf_pkg::CFG_DEGREE:  cur_deg = v[3:0];
      default:                 cur_root = v;
    endcase
  endtask

  task automatic add_req(ntt_tf_pkg::op_e op, int unsigned idx);
    request_t rq;
    rq.op  = op;
    rq.idx = idx[ntt_tf_pkg::IDX_W-1:0];
    pending_q.push_back(rq);
    if (rq.op == ntt_tf_pkg::OP_FWD) n_fwd++;
    else n_inv++;
  endtask

  task automatic run_phase(logic [63:0] q, logic [3:0] deg, logic [63:0] w, int unsigned cnt);
    int unsigned lg, n, idx;
    ntt_tf_pkg::op_e op;
    wait_idle();
    write_reg(ntt_tf_pkg::CFG_MODULUS, q);
    write_reg(ntt_tf_pkg::CFG_DEGREE, {60'd0, deg});
    write_reg(ntt_tf_pkg::CFG_ROOT, w);
    n_phase++;
    lg = (deg < 1) ? 1 :
         (deg > ntt_tf_pkg::MAX_LOG_DEGREE) ? ntt_tf_pkg::MAX_LOG_DEGREE : deg;
    n = 1 << lg;
    foreach (idx_list[i]) begin
      add_req(ntt_tf_pkg::OP_FWD, idx_list[i] % 16384);
      add_req(ntt_tf_pkg::OP_INV, idx_list[i] % 16384);
    end
    for (int i = 0; i < cnt; i++) begin
      op = ntt_tf_pkg::op_e'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 16383);
      else idx = $urandom_range(0, n - 1);
      if (idx >= n) n_oor++;
      add_req(op, idx);
    end
  endtask

  initial begin
    repeat (200_000_000) @(posedge clk_i);
    $display("tb_ntt_twiddle_factor_generator: errors");
    $finish;
  end

  initial begin
    logic [63:0] rq;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // reset configuration first
    for (int i = 0; i < 4; i++) begin
      add_req(ntt_tf_pkg::OP_FWD, i);
      add_req(ntt_tf_pkg::OP_INV, i);
    end
    idx_list = '{0, 1, 2, 3, 16383, 8192};
    run_phase(64'd17, 4'd4, 64'd3, 100);
    idx_list = '{0, 1, 4095, 4094, 4096, 16383};
    run_phase(64'd12289, 4'd12, 64'd11, 150);
    idx_list = '{0, 1, 255, 254, 256, 16383};
    run_phase(64'd7681, 4'd8, 64'd17, 150);
    // long stall on the output while requests keep coming
    wait_idle();
    for (int i = 0; i < 12; i++) add_req(ntt_tf_pkg::OP_FWD, $urandom_range(0, 255));
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    idx_list = '{0, 1, 16383, 16382, 8191, 2};
    run_phase(64'hFFFF_FFFF_0000_0001, 4'd14, 64'd7, 40);
    idx_list = '{0, 1, 2, 3, 16383, 5};
    run_phase(64'd2, 4'd1, 64'd5, 60);
    idx_list = '{0, 1, 7, 6, 8, 16383};
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 64'hFFFF_FFFF_FFFF_FFFE, 100);
    idx_list = '{0, 1, 16383, 16382, 100, 2};
    run_phase(64'd1, 4'd15, 64'd0, 60);
    idx_list = '{0, 1, 2, 3, 16383, 4};
    run_phase(64'd0, 4'd0, 64'd9, 40);
    idx_list = '{0, 1, 31, 30, 32, 16383};
    run_phase(64'd97, 4'd5, 64'd1000, 150);
    for (int p = 0; p < 4; p++) begin
      rq = {$urandom(), $urandom()};
      if (p < 3) rq = rq[15:0] | 64'd2;
      idx_list = '{0, 1, 2, 3, 16383, 9};
      run_phase(rq, 4'($urandom_range(1, 10)), {$urandom(), $urandom()}, (p < 3) ? 150 : 30);
    end
    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("covered %0d configurations, %0d forward and %0d inverse requests",
             n_phase, n_fwd, n_inv);
    $display("%0d beats checked, %0d random out-of-range indices", n_beats, n_oor);
    if (n_err == 0 && entry_q.size() == 0) begin
      $display("tb_ntt_twiddle_factor_generator: clean");
    end else begin
      $display("tb_ntt_twiddle_factor_generator: errors");
    end
    $finish;
  end

endmodule
